### rtl/bksd_pkg.sv
`timescale 1ns / 1ps
// Package for the braille key sequence decoder: event codes, key byte
// constants, the staged item and the decoded event types. No dependencies.
package bksd_pkg;

  // Event kinds on the result channel
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_BAR   = 2'd1,
    KIND_DOTS  = 2'd2,
    KIND_ROUTE = 2'd3
  } kind_e;

  // Advance bar codes
  typedef enum logic [2:0] {
    BAR_LEFT   = 3'd0,
    BAR_RIGHT  = 3'd1,
    BAR_LEFT1  = 3'd2,
    BAR_RIGHT1 = 3'd3,
    BAR_LEFT2  = 3'd4,
    BAR_RIGHT2 = 3'd5
  } bar_e;

  // Configuration register indexes
  localparam logic CFG_REVERSE = 1'b0;
  localparam logic CFG_CELLS   = 1'b1;

  // Reset values of the configuration registers
  localparam logic       REVERSE_RST = 1'b0;
  localparam logic [7:0] CELLS_RST   = 8'd40;

  // One-byte advance bar codes
  localparam logic [7:0] BYTE_BAR_LEFT  = 8'h83;
  localparam logic [7:0] BYTE_BAR_RIGHT = 8'h80;

  // Low nibble of three-byte advance bar codes
  localparam logic [3:0] NIB_LEFT1  = 4'h8;
  localparam logic [3:0] NIB_RIGHT1 = 4'h4;
  localparam logic [3:0] NIB_LEFT2  = 4'h2;
  localparam logic [3:0] NIB_RIGHT2 = 4'h1;

  // Bar byte bits flipped by reversal
  localparam logic [7:0] BAR_FLIP = 8'h03;

  // Sequence position: bytes of an open three-byte sequence
  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_FIRST  = 2'd1,
    SEQ_SECOND = 2'd2,
    SEQ_BAD    = 2'd3
  } seq_e;

  // Item that produces a result, held in the input register
  typedef struct packed {
    logic       is_final;   // final byte of a three-byte sequence
    logic [7:0] key_byte;
    logic [7:0] second;
  } item_t;

  // Decoded event
  typedef struct packed {
    kind_e      event_kind;
    logic [2:0] bar_code;
    logic [7:0] raw_code;
    logic [5:0] dot_keys;
    logic       space_bar;
    logic [7:0] routing_key;
  } event_t;

  // Exchange the two dot columns (bits 5:3 and 2:0)
  function automatic logic [5:0] swap_columns(input logic [5:0] v);
    swap_columns = {v[2:0], v[5:3]};
  endfunction

endpackage

### rtl/bksd_if.sv
`timescale 1ns / 1ps
// Stream interfaces of the braille key sequence decoder: key bytes in,
// key events out.

interface bksd_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface bksd_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [2:0] bar_code;
  logic [7:0] raw_code;
  logic [5:0] dot_keys;
  logic       space_bar;
  logic [7:0] routing_key;

  modport source (output valid, output event_kind, output bar_code, output raw_code,
                  output dot_keys, output space_bar, output routing_key, input ready);
  modport sink   (input valid, input event_kind, input bar_code, input raw_code,
                  input dot_keys, input space_bar, input routing_key, output ready);
endinterface

### rtl/bksd_seq.sv
`timescale 1ns / 1ps
// Sequence tracker and input register: counts the bytes of three-byte
// sequences and registers each byte that completes an event. Uses bksd_pkg.
module bksd_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  bksd_key_if.sink         key_i,
  input  logic             adv_i,
  output logic             item_valid_o,
  output bksd_pkg::item_t  item_o
);

  bksd_pkg::seq_e  seq_q, seq_d;
  logic [7:0]      held_q, held_d;
  logic            item_valid_q, item_valid_d;
  bksd_pkg::item_t item_q, item_d;
  logic            xfer;
  logic            emits;

  // Take a byte whenever the input register is free or drains this cycle
  assign key_i.ready = !item_valid_q || adv_i;
  assign xfer        = key_i.valid && key_i.ready;

  // Advance the sequence position
  always_comb begin
    seq_d  = seq_q;
    held_d = held_q;
    emits  = 1'b0;
    if (xfer) begin
      unique case (seq_q)
        bksd_pkg::SEQ_IDLE: begin
          if (key_i.key_byte == '0) seq_d = bksd_pkg::SEQ_FIRST;
          else                      emits = 1'b1;
        end
        bksd_pkg::SEQ_FIRST: begin
          held_d = key_i.key_byte;
          seq_d  = bksd_pkg::SEQ_SECOND;
        end
        default: begin
          // treat any later count as the final byte
          emits  = 1'b1;
          held_d = '0;
          seq_d  = bksd_pkg::SEQ_IDLE;
        end
      endcase
    end
  end

  // Load or drain the input register
  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    if (adv_i) item_valid_d = 1'b0;
    if (emits) begin
      item_valid_d     = 1'b1;
      item_d.is_final  = (seq_q != bksd_pkg::SEQ_IDLE);
      item_d.key_byte  = key_i.key_byte;
      item_d.second    = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= bksd_pkg::SEQ_IDLE;
      held_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      held_q       <= held_d;
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

### rtl/bksd_decode.sv
`timescale 1ns / 1ps
// Event decoder: turns a registered one-byte or three-byte item into a key
// event, mirroring it when reversal is on. Uses bksd_pkg.
module bksd_decode (
  input  bksd_pkg::item_t  item_i,
  input  logic             reverse_i,
  input  logic [7:0]       cells_i,
  output bksd_pkg::event_t evt_o
);

  logic [7:0] c;
  logic [7:0] third;
  logic [7:0] third_m;
  logic [7:0] second_m;
  logic [7:0] dots_src;
  logic       in_range;

  // Mirror the single byte
  always_comb begin
    c = item_i.key_byte;
    if (reverse_i) begin
      if (c[7]) c = c ^ bksd_pkg::BAR_FLIP;
      else      c = {1'b0, c[6], bksd_pkg::swap_columns(c[5:0])};
    end
  end

  // Mirror the final byte of a bar or routing sequence
  assign third    = item_i.key_byte;
  assign in_range = (third != '0) && (third <= cells_i);

  always_comb begin
    third_m = third;
    if (reverse_i) begin
      if (third[7])      third_m = {third[7:4], third[0], third[1], third[2], third[3]};
      else if (in_range) third_m = cells_i - third + 8'd1;
    end
  end

  // Mirror a three-byte dot event
  always_comb begin
    second_m = item_i.second;
    dots_src = third;
    if (reverse_i) begin
      second_m = {item_i.second[6], item_i.second[7],
                  bksd_pkg::swap_columns(item_i.second[5:0])};
      dots_src = {1'b0, third[6], bksd_pkg::swap_columns(third[5:0])};
    end
  end

  // Classify the event
  always_comb begin
    evt_o = '0;
    if (!item_i.is_final) begin
      if (c[7]) begin
        evt_o.raw_code = c;
        if (c == bksd_pkg::BYTE_BAR_LEFT) begin
          evt_o.event_kind = bksd_pkg::KIND_BAR;
          evt_o.bar_code   = bksd_pkg::BAR_LEFT;
        end else if (c == bksd_pkg::BYTE_BAR_RIGHT) begin
          evt_o.event_kind = bksd_pkg::KIND_BAR;
          evt_o.bar_code   = bksd_pkg::BAR_RIGHT;
        end
      end else begin
        evt_o.event_kind = bksd_pkg::KIND_DOTS;
        evt_o.raw_code   = {2'b00, c[5:0]};
        evt_o.dot_keys   = c[5:0];
        evt_o.space_bar  = c[6];
      end
    end else if (item_i.second == '0) begin
      evt_o.raw_code = third_m;
      if (third_m[7]) begin
        unique case (third_m[3:0])
          bksd_pkg::NIB_LEFT1: begin
            evt_o.event_kind = bksd_pkg::KIND_BAR;
            evt_o.bar_code   = bksd_pkg::BAR_LEFT1;
          end
          bksd_pkg::NIB_RIGHT1: begin
            evt_o.event_kind = bksd_pkg::KIND_BAR;
            evt_o.bar_code   = bksd_pkg::BAR_RIGHT1;
          end
          bksd_pkg::NIB_LEFT2: begin
            evt_o.event_kind = bksd_pkg::KIND_BAR;
            evt_o.bar_code   = bksd_pkg::BAR_LEFT2;
          end
          bksd_pkg::NIB_RIGHT2: begin
            evt_o.event_kind = bksd_pkg::KIND_BAR;
            evt_o.bar_code   = bksd_pkg::BAR_RIGHT2;
          end
          default: evt_o.event_kind = bksd_pkg::KIND_NONE;
        endcase
      end else if (in_range) begin
        evt_o.event_kind  = bksd_pkg::KIND_ROUTE;
        evt_o.routing_key = third_m;
      end
    end else begin
      evt_o.event_kind = bksd_pkg::KIND_DOTS;
      evt_o.raw_code   = second_m;
      evt_o.dot_keys   = dots_src[5:0];
      evt_o.space_bar  = dots_src[6];
    end
  end

endmodule

### rtl/braille_key_sequence_decoder.sv
`timescale 1ns / 1ps
// Top level of the braille key sequence decoder: configuration registers,
// sequence tracker, event decoder and result register. Uses bksd_pkg, bksd_if.
//
//   channel   dir  modport  payload
//   key_i     in   sink     key_byte
//   evt_o     out  source   event_kind bar_code raw_code dot_keys space_bar
//                           routing_key
//
// One byte per cycle while key_i is ready: a byte is registered on transfer,
// decoded and placed in the result register once that is free. Bytes that
// open or continue a sequence only update the tracker. Reset clears the
// sequence, the registers (no reversal, 40 cells) and both valid flags. A
// stalled result holds the input register, which then blocks key_i only
// once it too is full.
module braille_key_sequence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  bksd_key_if.sink    key_i,
  bksd_event_if.source evt_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic             reverse_q;
  logic [7:0]       cells_q;
  logic             item_valid;
  bksd_pkg::item_t  item;
  bksd_pkg::event_t evt_dec;
  logic             out_valid_q, out_valid_d;
  bksd_pkg::event_t out_q, out_d;
  logic             adv;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q <= bksd_pkg::REVERSE_RST;
      cells_q   <= bksd_pkg::CELLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bksd_pkg::CFG_REVERSE: reverse_q <= cfg_wdata_i[0];
        bksd_pkg::CFG_CELLS:   cells_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Move the input register on when the result register is free
  assign adv = item_valid && (!out_valid_q || evt_o.ready);

  bksd_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bksd_decode u_dec (
    .item_i    (item),
    .reverse_i (reverse_q),
    .cells_i   (cells_q),
    .evt_o     (evt_dec)
  );

  // Load or drain the result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (evt_o.ready) out_valid_d = 1'b0;
    if (adv) begin
      out_valid_d = 1'b1;
      out_d       = evt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign evt_o.valid       = out_valid_q;
  assign evt_o.event_kind  = out_q.event_kind;
  assign evt_o.bar_code    = out_q.bar_code;
  assign evt_o.raw_code    = out_q.raw_code;
  assign evt_o.dot_keys    = out_q.dot_keys;
  assign evt_o.space_bar   = out_q.space_bar;
  assign evt_o.routing_key = out_q.routing_key;

endmodule

### rtl/bksd_checker.sv
`timescale 1ns / 1ps
// Port checker for the braille key sequence decoder, bound to the top level.
// Uses bksd_pkg for the event kind codes.
module bksd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       evt_valid_i,
  input logic       evt_ready_i,
  input logic [1:0] event_kind_i,
  input logic [2:0] bar_code_i,
  input logic [7:0] raw_code_i,
  input logic [5:0] dot_keys_i,
  input logic       space_bar_i,
  input logic [7:0] routing_key_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i && $stable(raw_code_i) &&
                                     $stable(event_kind_i))
    else $error("stalled result changed");

  // Bar code only on bar events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (event_kind_i != bksd_pkg::KIND_BAR) |-> bar_code_i == '0)
    else $error("bar code on a non-bar event");

  // Routing number only on routing events, and then equal to the raw code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i |-> ((event_kind_i == bksd_pkg::KIND_ROUTE) ?
                     (routing_key_i == raw_code_i && routing_key_i != '0) :
                     (routing_key_i == '0)))
    else $error("routing number inconsistent");

  // Dot keys and space bar only on dot events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (event_kind_i != bksd_pkg::KIND_DOTS) |-> dot_keys_i == '0 && !space_bar_i)
    else $error("dot keys on a non-dot event");

endmodule

bind braille_key_sequence_decoder bksd_checker u_bksd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .evt_valid_i   (evt_o.valid),
  .evt_ready_i   (evt_o.ready),
  .event_kind_i  (evt_o.event_kind),
  .bar_code_i    (evt_o.bar_code),
  .raw_code_i    (evt_o.raw_code),
  .dot_keys_i    (evt_o.dot_keys),
  .space_bar_i   (evt_o.space_bar),
  .routing_key_i (evt_o.routing_key)
);
